[rtl/core/cip_acu_pkg.sv]
// Shared types, constants and saturating arithmetic helpers for the CIP
// advection cell update block. No dependencies.

package cip_acu_pkg;

   localparam int VALUE_WIDTH = 32;
   localparam int IW          = 48;
   localparam int LIM_EXP     = 46;
   localparam int FRAC        = 16;
   localparam int EXT_W       = 65;
   localparam int COURANT_W   = 16;
   localparam int QUEUE_DEPTH = 4;
   localparam int MUL_LAT     = 4;
   localparam int MUL_SPLIT   = 24;

   localparam logic [COURANT_W-1:0] COURANT_RESET = COURANT_W'(8192);

   typedef logic signed [VALUE_WIDTH-1:0] value_type;
   typedef logic signed [IW-1:0]          ival_type;
   typedef logic [COURANT_W-1:0]          courant_type;

   typedef struct packed {
      value_type value_left;
      value_type value_center;
      value_type value_right;
      value_type slope_left;
      value_type slope_center;
      value_type slope_right;
   } req_type;

   typedef struct packed {
      value_type new_value;
      value_type new_slope;
      logic      saturated;
   } rsp_type;

   typedef struct packed {
      logic     hit;
      ival_type v;
   } sat_type;

   typedef struct packed {
      logic      hit;
      value_type v;
   } osat_type;

   // classified stencil: upwind side already picked
   typedef struct packed {
      logic     left;
      logic     hit;
      ival_type fc;
      ival_type fu;
      ival_type gc;
      ival_type gu;
   } cls_type;

   typedef struct packed {
      logic     left;
      logic     hit;
      ival_type fc;
      ival_type fu;
      ival_type gc;
      ival_type gu;
      ival_type d;
      ival_type ga;
      ival_type g2;
      ival_type d2;
      ival_type t;
      ival_type a;
      ival_type d3;
      ival_type b;
      ival_type a2;
      ival_type t3;
      ival_type b2;
      ival_type x;
      ival_type v;
      ival_type h;
      ival_type hh;
   } ctx_type;

   localparam ival_type LIM_POS =
      {{(IW-LIM_EXP-1){1'b0}}, 1'b1, {LIM_EXP{1'b0}}};
   localparam ival_type LIM_NEG = -LIM_POS;

   localparam logic signed [IW:0] SUM_MAX =
      {{(IW-LIM_EXP){1'b0}}, 1'b1, {LIM_EXP{1'b0}}};
   localparam logic signed [EXT_W-1:0] EXT_LIM =
      {{(EXT_W-LIM_EXP-1){1'b0}}, 1'b1, {LIM_EXP{1'b0}}};
   localparam logic signed [EXT_W-1:0] VMAX_E =
      {{(EXT_W-VALUE_WIDTH+1){1'b0}}, {(VALUE_WIDTH-1){1'b1}}};
   localparam logic signed [EXT_W-1:0] VMIN_E = ~VMAX_E;
   localparam value_type VAL_MAX = {1'b0, {(VALUE_WIDTH-1){1'b1}}};
   localparam value_type VAL_MIN = {1'b1, {(VALUE_WIDTH-1){1'b0}}};

   function automatic sat_type sadd(ival_type a, ival_type b);
      logic signed [IW:0] s;
      sat_type r;
      s = {a[IW-1], a} + {b[IW-1], b};
      r.hit = 1'b0;
      r.v   = s[IW-1:0];
      if (s > SUM_MAX) begin
         r.hit = 1'b1;
         r.v   = LIM_POS;
      end else if (s < -SUM_MAX) begin
         r.hit = 1'b1;
         r.v   = LIM_NEG;
      end
      return r;
   endfunction

   function automatic sat_type clamp_in(value_type x);
      logic signed [EXT_W-1:0] e;
      sat_type r;
      e = {{(EXT_W-VALUE_WIDTH){x[VALUE_WIDTH-1]}}, x};
      r.hit = 1'b0;
      r.v   = e[IW-1:0];
      if (e > EXT_LIM) begin
         r.hit = 1'b1;
         r.v   = LIM_POS;
      end else if (e < -EXT_LIM) begin
         r.hit = 1'b1;
         r.v   = LIM_NEG;
      end
      return r;
   endfunction

   function automatic osat_type out_sat(ival_type v);
      logic signed [EXT_W-1:0] e;
      osat_type r;
      e = {{(EXT_W-IW){v[IW-1]}}, v};
      r.hit = 1'b0;
      r.v   = e[VALUE_WIDTH-1:0];
      if (e > VMAX_E) begin
         r.hit = 1'b1;
         r.v   = VAL_MAX;
      end else if (e < VMIN_E) begin
         r.hit = 1'b1;
         r.v   = VAL_MIN;
      end
      return r;
   endfunction

endpackage

[rtl/core/cip_acu_mul.sv]
// Four-stage Q16.16 multiplier: floor rounding, clamp to the intermediate range.
// Depends on cip_acu_pkg.

module cip_acu_mul (
   input  logic                  clock,
   input  logic                  en,
   input  cip_acu_pkg::ival_type op_a,
   input  cip_acu_pkg::ival_type op_b,
   output cip_acu_pkg::sat_type  prod
);

   localparam int IW    = cip_acu_pkg::IW;
   localparam int MW    = IW - 1;
   localparam int SPLIT = cip_acu_pkg::MUL_SPLIT;
   localparam int HW    = MW - SPLIT;
   localparam int PW    = 2 * MW;
   localparam int FRAC  = cip_acu_pkg::FRAC;
   localparam int QW    = PW - FRAC + 1;
   localparam logic [QW-1:0] QLIM = QW'(1) << cip_acu_pkg::LIM_EXP;

   logic                    neg1_ff, neg1_in;
   logic [MW-1:0]           ma1_ff, ma1_in, mb1_ff, mb1_in;
   logic                    neg2_ff;
   logic [MW+SPLIT-1:0]     lo2_ff, lo2_in;
   logic [MW+HW-1:0]        hi2_ff, hi2_in;
   logic                    neg3_ff, rnd3_ff, rnd3_in;
   logic [PW-1:0]           p3_ff, p3_in;
   cip_acu_pkg::sat_type    prod_ff, prod_in;

   always_comb begin
      cip_acu_pkg::ival_type aa;
      cip_acu_pkg::ival_type ab;
      aa = op_a[IW-1] ? -op_a : op_a;
      ab = op_b[IW-1] ? -op_b : op_b;
      neg1_in = op_a[IW-1] ^ op_b[IW-1];
      ma1_in  = aa[MW-1:0];
      mb1_in  = ab[MW-1:0];
   end

   assign lo2_in  = (MW+SPLIT)'(ma1_ff) * (MW+SPLIT)'(mb1_ff[SPLIT-1:0]);
   assign hi2_in  = (MW+HW)'(ma1_ff) * (MW+HW)'(mb1_ff[MW-1:SPLIT]);
   assign p3_in   = PW'(lo2_ff) + (PW'(hi2_ff) << SPLIT);
   assign rnd3_in = neg2_ff && (lo2_ff[FRAC-1:0] != '0);

   always_comb begin
      logic [QW-1:0] q;
      cip_acu_pkg::ival_type mag;
      q = QW'(p3_ff[PW-1:FRAC]) + QW'(rnd3_ff);
      prod_in.hit = 1'b0;
      mag = q[IW-1:0];
      if (q > QLIM) begin
         prod_in.hit = 1'b1;
         mag = cip_acu_pkg::LIM_POS;
      end
      prod_in.v = neg3_ff ? -mag : mag;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         neg1_ff <= neg1_in;
         ma1_ff  <= ma1_in;
         mb1_ff  <= mb1_in;
         neg2_ff <= neg1_ff;
         lo2_ff  <= lo2_in;
         hi2_ff  <= hi2_in;
         neg3_ff <= neg2_ff;
         rnd3_ff <= rnd3_in;
         p3_ff   <= p3_in;
         prod_ff <= prod_in;
      end
   end

   assign prod = prod_ff;

endmodule

[rtl/core/cip_acu_front.sv]
// Front end: takes stencil items, clamps inputs and picks the upwind side.
// Depends on cip_acu_pkg.

module cip_acu_front (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  cip_acu_pkg::req_type req_data,
   output logic                 cls_valid,
   input  logic                 cls_ready,
   output cip_acu_pkg::cls_type cls_data
);

   localparam int IW = cip_acu_pkg::IW;

   logic                 vld_ff;
   cip_acu_pkg::cls_type data_ff, data_in;

   always_comb begin
      cip_acu_pkg::sat_type fl, fc, fr, gl, gc, gr;
      fl = cip_acu_pkg::clamp_in(req_data.value_left);
      fc = cip_acu_pkg::clamp_in(req_data.value_center);
      fr = cip_acu_pkg::clamp_in(req_data.value_right);
      gl = cip_acu_pkg::clamp_in(req_data.slope_left);
      gc = cip_acu_pkg::clamp_in(req_data.slope_center);
      gr = cip_acu_pkg::clamp_in(req_data.slope_right);
      // zero velocity goes upwind to the left
      data_in.left = !fc.v[IW-1];
      data_in.hit  = fl.hit | fc.hit | fr.hit | gl.hit | gc.hit | gr.hit;
      data_in.fc   = fc.v;
      data_in.gc   = gc.v;
      data_in.fu   = data_in.left ? fl.v : fr.v;
      data_in.gu   = data_in.left ? gl.v : gr.v;
   end

   assign req_ready = !vld_ff || cls_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= 1'b0;
      end else if (req_ready) begin
         vld_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         data_ff <= data_in;
      end
   end

   assign cls_valid = vld_ff;
   assign cls_data  = data_ff;

endmodule

[rtl/core/cip_acu_queue.sv]
// Short FIFO of classified items between front and back end.
// Depends on cip_acu_pkg.

module cip_acu_queue #(
   parameter int DEPTH = cip_acu_pkg::QUEUE_DEPTH
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push_valid,
   output logic                 push_ready,
   input  cip_acu_pkg::cls_type push_data,
   output logic                 pop_valid,
   input  logic                 pop_ready,
   output cip_acu_pkg::cls_type pop_data
);

   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   cip_acu_pkg::cls_type mem_ff [DEPTH];
   logic [AW-1:0]        wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]        count_ff, count_in;
   logic                 push, pop;

   assign push_ready = count_ff != CW'(DEPTH);
   assign pop_valid  = count_ff != '0;
   assign push       = push_valid && push_ready;
   assign pop        = pop_valid && pop_ready;
   assign pop_data   = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == AW'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == AW'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(DEPTH))
      else $error("queue count above depth");

   a_count_inc: assert property (@(posedge clock) disable iff (reset)
      (push && !pop) |=> (count_ff == $past(count_ff) + 1'b1))
      else $error("queue count did not follow push");

   a_ptr_gap: assert property (@(posedge clock) disable iff (reset)
      (count_ff == '0) |-> (wr_ptr_ff == rd_ptr_ff))
      else $error("empty queue with pointers apart");

endmodule

[rtl/core/cip_acu_back.sv]
// Back end: coefficient build, cubic evaluation, slope correction, output.
// Depends on cip_acu_pkg and cip_acu_mul.

module cip_acu_back (
   input  logic                     clock,
   input  logic                     reset,
   input  cip_acu_pkg::courant_type courant,
   input  logic                     pop_valid,
   output logic                     pop_ready,
   input  cip_acu_pkg::cls_type     pop_data,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output cip_acu_pkg::rsp_type     rsp_data
);

   localparam int IW   = cip_acu_pkg::IW;
   localparam int STEP = cip_acu_pkg::MUL_LAT + 1;
   localparam int ST_D  = 1;
   localparam int ST_D2 = 2;
   localparam int ST_A  = 3;
   localparam int ST_B  = 4;
   localparam int ST_X  = STEP;
   localparam int ST_V1 = ST_X + STEP;
   localparam int ST_V2 = ST_V1 + STEP;
   localparam int ST_V3 = ST_V2 + STEP;
   localparam int NS    = ST_V3 + STEP;

   logic                  en;
   logic [NS:1]           vld_ff, vld_in;
   cip_acu_pkg::ctx_type  ctx_ff [1:NS];
   cip_acu_pkg::ctx_type  ctx_in [1:NS];
   cip_acu_pkg::ctx_type  ctx0;
   cip_acu_pkg::ival_type cour;
   cip_acu_pkg::sat_type  mx, p1, q1, p2, q2, p3, q3, q4;
   logic                  rsp_vld_ff;
   cip_acu_pkg::rsp_type  rsp_data_ff, rsp_data_in;

   assign en        = !rsp_vld_ff || rsp_ready;
   assign pop_ready = en;
   assign cour      = {{(IW-cip_acu_pkg::COURANT_W){1'b0}}, courant};

   always_comb begin
      ctx0      = '0;
      ctx0.left = pop_data.left;
      ctx0.hit  = pop_data.hit;
      ctx0.fc   = pop_data.fc;
      ctx0.fu   = pop_data.fu;
      ctx0.gc   = pop_data.gc;
      ctx0.gu   = pop_data.gu;
   end

   cip_acu_mul u_mul_x  (.clock, .en, .op_a(-ctx0.fc), .op_b(cour), .prod(mx));
   cip_acu_mul u_mul_p1 (.clock, .en, .op_a(ctx_ff[ST_X].a), .op_b(ctx_ff[ST_X].x),
                         .prod(p1));
   cip_acu_mul u_mul_q1 (.clock, .en, .op_a(ctx_ff[ST_X].t3), .op_b(ctx_ff[ST_X].x),
                         .prod(q1));
   cip_acu_mul u_mul_p2 (.clock, .en, .op_a(ctx_ff[ST_V1].v), .op_b(ctx_ff[ST_V1].x),
                         .prod(p2));
   cip_acu_mul u_mul_q2 (.clock, .en, .op_a(ctx_ff[ST_V1].h), .op_b(ctx_ff[ST_V1].x),
                         .prod(q2));
   cip_acu_mul u_mul_p3 (.clock, .en, .op_a(ctx_ff[ST_V2].v), .op_b(ctx_ff[ST_V2].x),
                         .prod(p3));
   cip_acu_mul u_mul_q3 (.clock, .en, .op_a(ctx_ff[ST_V2].h), .op_b(ctx_ff[ST_V2].h),
                         .prod(q3));
   cip_acu_mul u_mul_q4 (.clock, .en, .op_a(ctx_ff[ST_V3].hh), .op_b(cour),
                         .prod(q4));

   always_comb begin
      cip_acu_pkg::ctx_type c;
      cip_acu_pkg::sat_type s0, s1, s2;

      for (int k = 2; k <= NS; k++) begin
         ctx_in[k] = ctx_ff[k-1];
      end

      c  = ctx0;
      s0 = cip_acu_pkg::sadd(c.fc, -c.fu);
      s1 = cip_acu_pkg::sadd(c.gc, c.gu);
      s2 = cip_acu_pkg::sadd(c.gc, c.gc);
      ctx_in[ST_D]     = c;
      ctx_in[ST_D].d   = s0.v;
      ctx_in[ST_D].ga  = s1.v;
      ctx_in[ST_D].g2  = s2.v;
      ctx_in[ST_D].hit = c.hit | s0.hit | s1.hit | s2.hit;

      c  = ctx_ff[ST_D2-1];
      s0 = cip_acu_pkg::sadd(c.d, c.d);
      s1 = cip_acu_pkg::sadd(c.g2, c.gu);
      ctx_in[ST_D2].d2  = s0.v;
      ctx_in[ST_D2].t   = s1.v;
      ctx_in[ST_D2].hit = c.hit | s0.hit | s1.hit;

      c  = ctx_ff[ST_A-1];
      s0 = cip_acu_pkg::sadd(c.ga, c.left ? -c.d2 : c.d2);
      s1 = cip_acu_pkg::sadd(c.d2, c.d);
      ctx_in[ST_A].a   = s0.v;
      ctx_in[ST_A].d3  = s1.v;
      ctx_in[ST_A].hit = c.hit | s0.hit | s1.hit;

      c  = ctx_ff[ST_B-1];
      s0 = cip_acu_pkg::sadd(-c.d3, c.left ? c.t : -c.t);
      s1 = cip_acu_pkg::sadd(c.a, c.a);
      ctx_in[ST_B].b   = s0.v;
      ctx_in[ST_B].a2  = s1.v;
      ctx_in[ST_B].hit = c.hit | s0.hit | s1.hit;

      c  = ctx_ff[ST_X-1];
      s0 = cip_acu_pkg::sadd(c.a2, c.a);
      s1 = cip_acu_pkg::sadd(c.b, c.b);
      ctx_in[ST_X].t3  = s0.v;
      ctx_in[ST_X].b2  = s1.v;
      ctx_in[ST_X].x   = mx.v;
      ctx_in[ST_X].hit = c.hit | s0.hit | s1.hit | mx.hit;

      c  = ctx_ff[ST_V1-1];
      s0 = cip_acu_pkg::sadd(p1.v, c.b);
      s1 = cip_acu_pkg::sadd(q1.v, c.b2);
      ctx_in[ST_V1].v   = s0.v;
      ctx_in[ST_V1].h   = s1.v;
      ctx_in[ST_V1].hit = c.hit | s0.hit | s1.hit | p1.hit | q1.hit;

      c  = ctx_ff[ST_V2-1];
      s0 = cip_acu_pkg::sadd(p2.v, c.gc);
      s1 = cip_acu_pkg::sadd(q2.v, c.gc);
      ctx_in[ST_V2].v   = s0.v;
      ctx_in[ST_V2].h   = s1.v;
      ctx_in[ST_V2].hit = c.hit | s0.hit | s1.hit | p2.hit | q2.hit;

      c  = ctx_ff[ST_V3-1];
      s0 = cip_acu_pkg::sadd(p3.v, c.fc);
      ctx_in[ST_V3].v   = s0.v;
      ctx_in[ST_V3].hh  = q3.v;
      ctx_in[ST_V3].hit = c.hit | s0.hit | p3.hit | q3.hit;

      c  = ctx_ff[NS-1];
      s0 = cip_acu_pkg::sadd(c.h, -q4.v);
      ctx_in[NS].h   = s0.v;
      ctx_in[NS].hit = c.hit | s0.hit | q4.hit;
   end

   assign vld_in = {vld_ff[NS-1:1], pop_valid};

   always_comb begin
      cip_acu_pkg::osat_type ov, oh;
      ov = cip_acu_pkg::out_sat(ctx_ff[NS].v);
      oh = cip_acu_pkg::out_sat(ctx_ff[NS].h);
      rsp_data_in.new_value = ov.v;
      rsp_data_in.new_slope = oh.v;
      rsp_data_in.saturated = ctx_ff[NS].hit | ov.hit | oh.hit;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff     <= '0;
         rsp_vld_ff <= 1'b0;
      end else if (en) begin
         vld_ff     <= vld_in;
         rsp_vld_ff <= vld_ff[NS];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         ctx_ff <= ctx_in;
         if (vld_ff[NS]) begin
            rsp_data_ff <= rsp_data_in;
         end
      end
   end

   assign rsp_valid = rsp_vld_ff;
   assign rsp_data  = rsp_data_ff;

   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      !en |=> $stable(vld_ff))
      else $error("pipeline moved during output stall");

   a_pop_enter: assert property (@(posedge clock) disable iff (reset)
      (pop_valid && pop_ready) |=> vld_ff[1])
      else $error("popped item missing from first stage");

   a_out_load: assert property (@(posedge clock) disable iff (reset)
      (en && vld_ff[NS]) |=> rsp_vld_ff)
      else $error("finished item not loaded into output register");

endmodule

[rtl/core/cip_advection_cell_update_top.sv]
// Top level of the CIP advection cell update: courant register, front end,
// queue and back end. Depends on cip_acu_pkg, cip_acu_front, cip_acu_queue,
// cip_acu_back.

// One item per clock cycle sustained while the output is not stalled. An item
// passes through the front register, the queue, 25 back stages and the output
// register. The back stages hold five dependent steps, each through a
// four-stage 48-bit multiplier, four of them followed by an add. While
// the output waits, the front keeps taking items until the QUEUE_DEPTH-entry
// queue and the front register are full. Write courant only when idle.

module cip_advection_cell_update_top #(
   parameter int QUEUE_DEPTH = cip_acu_pkg::QUEUE_DEPTH
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_ready,
   input  cip_acu_pkg::req_type     req_data,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output cip_acu_pkg::rsp_type     rsp_data,
   input  logic                     csr_wr_en,
   input  cip_acu_pkg::courant_type csr_wr_data
);

   cip_acu_pkg::courant_type courant_ff;
   logic                     cls_valid, cls_ready, deq_valid, deq_ready;
   cip_acu_pkg::cls_type     cls_data, deq_data;

   always_ff @(posedge clock) begin
      if (reset) begin
         courant_ff <= cip_acu_pkg::COURANT_RESET;
      end else if (csr_wr_en) begin
         courant_ff <= csr_wr_data;
      end
   end

   cip_acu_front u_front (
      .clock,
      .reset,
      .req_valid,
      .req_ready,
      .req_data,
      .cls_valid,
      .cls_ready,
      .cls_data
   );

   cip_acu_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
      .clock,
      .reset,
      .push_valid (cls_valid),
      .push_ready (cls_ready),
      .push_data  (cls_data),
      .pop_valid  (deq_valid),
      .pop_ready  (deq_ready),
      .pop_data   (deq_data)
   );

   cip_acu_back u_back (
      .clock,
      .reset,
      .courant    (courant_ff),
      .pop_valid  (deq_valid),
      .pop_ready  (deq_ready),
      .pop_data   (deq_data),
      .rsp_valid,
      .rsp_ready,
      .rsp_data
   );

endmodule

[tb/tb_cip_advection_cell_update_top.sv]
// Self-checking testbench for cip_advection_cell_update_top: drives stencil
// items, predicts the cell updates of untyped rows in Q16.16 and checks every result.
// Depends on cip_acu_pkg and the RTL of the block.
`timescale 1ns / 1ps

module tb_cip_advection_cell_update_top;

   localparam int     Q1        = 65536;
   localparam longint Q_LIM     = 64'sd70368744177664;
   localparam int     RUN_LIMIT = 200000;
   localparam int     PHASE_LEN = 188;
   localparam int     HOLD_LEN  = 400;

   typedef struct {
      cip_acu_pkg::courant_type courant;
      cip_acu_pkg::req_type     item;
      bit                       typed;
      cip_acu_pkg::rsp_type     want;
   } stim_row_type;

   logic                     clock = 1'b0;
   logic                     reset;
   logic                     req_valid;
   logic                     req_ready;
   cip_acu_pkg::req_type     req_data;
   logic                     rsp_valid;
   logic                     rsp_ready;
   cip_acu_pkg::rsp_type     rsp_data;
   logic                     csr_wr_en;
   cip_acu_pkg::courant_type csr_wr_data;

   cip_acu_pkg::rsp_type     updates_due[$];
   stim_row_type             dir_rows[$];
   cip_acu_pkg::courant_type courant_now;
   bit                       clip_seen;
   int                       bad_updates = 0;
   int                       updates_seen = 0;
   int                       burst_left;
   int                       cycles = 0;

   cip_advection_cell_update_top dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_data    (rsp_data),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles > RUN_LIMIT) begin
         $display("FAIL");
         $finish;
      end
   end

   // Q16.16 arithmetic, intermediates held within +-2^46
   function automatic longint q_clamp(longint v);
      if (v > Q_LIM) begin
         clip_seen = 1'b1;
         return Q_LIM;
      end
      if (v < -Q_LIM) begin
         clip_seen = 1'b1;
         return -Q_LIM;
      end
      return v;
   endfunction

   function automatic longint q_add(longint a, longint b);
      return q_clamp(a + b);
   endfunction

   // product floored to Q16.16
   function automatic longint q_mul(longint a, longint b);
      logic signed [127:0] wa, wb, p, lim;
      wa  = a;
      wb  = b;
      lim = Q_LIM;
      p   = (wa * wb) >>> 16;
      if (p > lim) begin
         clip_seen = 1'b1;
         return Q_LIM;
      end
      if (p < -lim) begin
         clip_seen = 1'b1;
         return -Q_LIM;
      end
      return longint'(p);
   endfunction

   function automatic cip_acu_pkg::value_type out_clip(longint v);
      if (v > longint'(cip_acu_pkg::VAL_MAX)) begin
         clip_seen = 1'b1;
         return cip_acu_pkg::VAL_MAX;
      end
      if (v < longint'(cip_acu_pkg::VAL_MIN)) begin
         clip_seen = 1'b1;
         return cip_acu_pkg::VAL_MIN;
      end
      return cip_acu_pkg::value_type'(v);
   endfunction

   function automatic cip_acu_pkg::rsp_type advect_cell(cip_acu_pkg::req_type r,
                                                        cip_acu_pkg::courant_type cr);
      longint               fl, fc, fr, gl, gc, gr, fu, gu, d, a, b, x, t, v, h, c;
      bit                   upl;
      cip_acu_pkg::rsp_type res;
      clip_seen = 1'b0;
      fl  = q_clamp(longint'(r.value_left));
      fc  = q_clamp(longint'(r.value_center));
      fr  = q_clamp(longint'(r.value_right));
      gl  = q_clamp(longint'(r.slope_left));
      gc  = q_clamp(longint'(r.slope_center));
      gr  = q_clamp(longint'(r.slope_right));
      c   = longint'(cr);
      upl = fc >= 0;
      fu  = upl ? fl : fr;
      gu  = upl ? gl : gr;
      d   = q_add(fc, -fu);
      a   = q_add(gc, gu);
      t   = q_add(d, d);
      a   = upl ? q_add(a, -t) : q_add(a, t);
      t   = q_add(q_add(gc, gc), gu);
      b   = -q_add(q_add(d, d), d);
      b   = upl ? q_add(b, t) : q_add(b, -t);
      x   = q_mul(-fc, c);
      v   = q_add(q_mul(a, x), b);
      v   = q_add(q_mul(v, x), gc);
      v   = q_add(q_mul(v, x), fc);
      t   = q_add(q_add(a, a), a);
      h   = q_add(q_mul(t, x), q_add(b, b));
      h   = q_add(q_mul(h, x), gc);
      h   = q_add(h, -q_mul(q_mul(h, h), c));
      res.new_value = out_clip(v);
      res.new_slope = out_clip(h);
      res.saturated = clip_seen;
      return res;
   endfunction

   function automatic cip_acu_pkg::req_type stencil(
      cip_acu_pkg::value_type fl, cip_acu_pkg::value_type fc,
      cip_acu_pkg::value_type fr, cip_acu_pkg::value_type gl,
      cip_acu_pkg::value_type gc, cip_acu_pkg::value_type gr);
      cip_acu_pkg::req_type s;
      s.value_left   = fl;
      s.value_center = fc;
      s.value_right  = fr;
      s.slope_left   = gl;
      s.slope_center = gc;
      s.slope_right  = gr;
      return s;
   endfunction

   function automatic cip_acu_pkg::rsp_type update(cip_acu_pkg::value_type v,
                                                   cip_acu_pkg::value_type s,
                                                   logic sat);
      cip_acu_pkg::rsp_type u;
      u.new_value = v;
      u.new_slope = s;
      u.saturated = sat;
      return u;
   endfunction

   function automatic cip_acu_pkg::value_type edge_word();
      case ($urandom_range(0, 6))
         0: return cip_acu_pkg::VAL_MAX;
         1: return cip_acu_pkg::VAL_MIN;
         2: return '0;
         3: return cip_acu_pkg::value_type'(1);
         4: return '1;
         5: return cip_acu_pkg::value_type'(Q1);
         default: return cip_acu_pkg::value_type'($urandom);
      endcase
   endfunction

   function automatic cip_acu_pkg::value_type near_word(int centre, int spread);
      return cip_acu_pkg::value_type'(centre + int'($urandom_range(0, 2 * spread))
                                      - spread);
   endfunction

   // mostly smooth fields around a moderate velocity, the rest noise and edges
   function automatic cip_acu_pkg::req_type random_stencil();
      int kind, base;
      kind = $urandom_range(0, 9);
      if (kind <= 5) begin
         base = int'($urandom_range(0, 8 * 2 * Q1)) - 8 * Q1;
         return stencil(near_word(base, Q1), cip_acu_pkg::value_type'(base),
                        near_word(base, Q1),
                        near_word(0, Q1), near_word(0, Q1), near_word(0, Q1));
      end
      if (kind <= 7)
         return stencil($urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
      if (kind == 8)
         return stencil(edge_word(), edge_word(), edge_word(),
                        edge_word(), edge_word(), edge_word());
      return stencil($urandom, '0, $urandom, $urandom, $urandom, $urandom);
   endfunction

   task automatic add_row(cip_acu_pkg::courant_type c, cip_acu_pkg::req_type s,
                          bit typed = 1'b0, cip_acu_pkg::rsp_type w = '0);
      stim_row_type row;
      row.courant = c;
      row.item    = s;
      row.typed   = typed;
      row.want    = w;
      dir_rows.push_back(row);
   endtask

   task automatic offer(cip_acu_pkg::req_type item, bit typed,
                        cip_acu_pkg::rsp_type want);
      req_valid <= 1'b1;
      req_data  <= item;
      do @(posedge clock); while (!req_ready);
      updates_due.push_back(typed ? want : advect_cell(item, courant_now));
   endtask

   task automatic idle(int n);
      req_valid <= 1'b0;
      repeat (n) @(posedge clock);
   endtask

   task automatic pace();
      int gap;
      if (burst_left > 0) begin
         burst_left--;
      end else begin
         gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
         burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(40, 120)
                                                  : $urandom_range(1, 12);
         if (gap > 0)
            idle(gap);
      end
   endtask

   task automatic settle();
      while (updates_due.size() != 0)
         @(posedge clock);
   endtask

   task automatic retune(cip_acu_pkg::courant_type c);
      idle(1);
      settle();
      csr_wr_en   <= 1'b1;
      csr_wr_data <= c;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
      courant_now = c;
   endtask

   always @(posedge clock) begin : check_updates
      cip_acu_pkg::rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         updates_seen++;
         if (updates_due.size() == 0) begin
            $display("%0t: unexpected update, expected none, got %p", $time, rsp_data);
            bad_updates++;
         end else begin
            want = updates_due.pop_front();
            if (rsp_data.new_value !== want.new_value) begin
               $display("%0t: new_value expected %0d got %0d",
                        $time, want.new_value, rsp_data.new_value);
               bad_updates++;
            end
            if (rsp_data.new_slope !== want.new_slope) begin
               $display("%0t: new_slope expected %0d got %0d",
                        $time, want.new_slope, rsp_data.new_slope);
               bad_updates++;
            end
            if (rsp_data.saturated !== want.saturated) begin
               $display("%0t: saturated expected %0b got %0b",
                        $time, want.saturated, rsp_data.saturated);
               bad_updates++;
            end
         end
      end
   end

   // output stalls; one long hold-off so the block backs up into its input
   initial begin : drain_side
      int  mode, span;
      bit  held;
      held      = 1'b0;
      rsp_ready = 1'b0;
      wait (!reset);
      forever begin
         mode = $urandom_range(0, 3);
         span = $urandom_range(20, 120);
         repeat (span) begin
            @(posedge clock);
            if (!held && updates_seen >= 250) begin
               held = 1'b1;
               rsp_ready <= 1'b0;
               repeat (HOLD_LEN) @(posedge clock);
            end
            case (mode)
               0: rsp_ready <= 1'b1;
               1: rsp_ready <= 1'($urandom_range(0, 1));
               2: rsp_ready <= ($urandom_range(0, 3) == 0);
               default: rsp_ready <= ($urandom_range(0, 7) != 0);
            endcase
         end
      end
   end

   initial begin : feed_side
      cip_acu_pkg::courant_type phase_courant[6];
      reset       = 1'b1;
      req_valid   = 1'b0;
      req_data    = '0;
      csr_wr_en   = 1'b0;
      csr_wr_data = '0;
      courant_now = cip_acu_pkg::COURANT_RESET;
      burst_left  = 0;

      phase_courant = '{16'd4096, 16'd65535, 16'd1, 16'd0, 16'd32768, 16'd0};
      phase_courant[3] = cip_acu_pkg::courant_type'($urandom_range(0, 65535));
      phase_courant[5] = cip_acu_pkg::courant_type'($urandom_range(1, 16384));

      // reset courant
      add_row(cip_acu_pkg::COURANT_RESET, stencil(0, 0, 0, 0, 0, 0), 1'b1,
              update(0, 0, 1'b0));
      add_row(cip_acu_pkg::COURANT_RESET, stencil(Q1, Q1, Q1, 0, 0, 0), 1'b1,
              update(Q1, 0, 1'b0));
      add_row(cip_acu_pkg::COURANT_RESET, stencil(-Q1, -Q1, -Q1, 0, 0, 0), 1'b1,
              update(-Q1, 0, 1'b0));
      // zero velocity: value unchanged, slope only gets the nonlinear term
      add_row(cip_acu_pkg::COURANT_RESET,
              stencil(cip_acu_pkg::VAL_MAX, 0, cip_acu_pkg::VAL_MIN,
                      cip_acu_pkg::VAL_MIN, 0, cip_acu_pkg::VAL_MAX), 1'b1,
              update(0, 0, 1'b0));
      add_row(cip_acu_pkg::COURANT_RESET,
              stencil(3 * Q1, 0, -Q1, Q1, 2 * Q1, -4 * Q1), 1'b1,
              update(0, 32'sh0001_8000, 1'b0));
      add_row(cip_acu_pkg::COURANT_RESET, stencil(Q1, 2 * Q1, 3 * Q1, Q1, Q1, Q1));
      add_row(cip_acu_pkg::COURANT_RESET, stencil(3 * Q1, -2 * Q1, Q1, -Q1, -Q1, -Q1));
      add_row(cip_acu_pkg::COURANT_RESET,
              stencil(cip_acu_pkg::VAL_MAX, cip_acu_pkg::VAL_MAX, cip_acu_pkg::VAL_MAX,
                      cip_acu_pkg::VAL_MAX, cip_acu_pkg::VAL_MAX, cip_acu_pkg::VAL_MAX));
      add_row(cip_acu_pkg::COURANT_RESET,
              stencil(cip_acu_pkg::VAL_MIN, cip_acu_pkg::VAL_MIN, cip_acu_pkg::VAL_MIN,
                      cip_acu_pkg::VAL_MIN, cip_acu_pkg::VAL_MIN, cip_acu_pkg::VAL_MIN));
      add_row(cip_acu_pkg::COURANT_RESET,
              stencil(cip_acu_pkg::VAL_MIN, cip_acu_pkg::VAL_MAX, cip_acu_pkg::VAL_MIN,
                      cip_acu_pkg::VAL_MAX, cip_acu_pkg::VAL_MIN, cip_acu_pkg::VAL_MAX));
      add_row(cip_acu_pkg::COURANT_RESET,
              stencil(cip_acu_pkg::VAL_MAX, cip_acu_pkg::VAL_MIN, cip_acu_pkg::VAL_MAX,
                      cip_acu_pkg::VAL_MIN, cip_acu_pkg::VAL_MAX, cip_acu_pkg::VAL_MIN));
      add_row(cip_acu_pkg::COURANT_RESET, stencil(-Q1, 1, Q1, Q1, -Q1, Q1));
      add_row(cip_acu_pkg::COURANT_RESET, stencil(-Q1, -1, Q1, Q1, -Q1, Q1));
      // courant zero: no displacement
      add_row(16'd0,
              stencil(cip_acu_pkg::VAL_MIN, cip_acu_pkg::VAL_MAX, cip_acu_pkg::VAL_MIN,
                      cip_acu_pkg::VAL_MIN, cip_acu_pkg::VAL_MAX, cip_acu_pkg::VAL_MIN),
              1'b1, update(cip_acu_pkg::VAL_MAX, cip_acu_pkg::VAL_MAX, 1'b0));
      add_row(16'd0,
              stencil(cip_acu_pkg::VAL_MAX, cip_acu_pkg::VAL_MIN, cip_acu_pkg::VAL_MAX,
                      cip_acu_pkg::VAL_MAX, cip_acu_pkg::VAL_MIN, cip_acu_pkg::VAL_MAX),
              1'b1, update(cip_acu_pkg::VAL_MIN, cip_acu_pkg::VAL_MIN, 1'b0));
      add_row(16'd0, stencil(Q1, -5 * Q1, 7 * Q1, 3 * Q1, -Q1, 2 * Q1), 1'b1,
              update(-5 * Q1, -Q1, 1'b0));
      // largest courant
      add_row(16'd65535,
              stencil(cip_acu_pkg::VAL_MAX, cip_acu_pkg::VAL_MAX, cip_acu_pkg::VAL_MAX,
                      cip_acu_pkg::VAL_MAX, cip_acu_pkg::VAL_MAX, cip_acu_pkg::VAL_MAX));
      add_row(16'd65535,
              stencil(cip_acu_pkg::VAL_MIN, cip_acu_pkg::VAL_MIN, cip_acu_pkg::VAL_MIN,
                      cip_acu_pkg::VAL_MIN, cip_acu_pkg::VAL_MIN, cip_acu_pkg::VAL_MIN));
      add_row(16'd65535,
              stencil(cip_acu_pkg::VAL_MIN, cip_acu_pkg::VAL_MAX, cip_acu_pkg::VAL_MIN,
                      cip_acu_pkg::VAL_MAX, cip_acu_pkg::VAL_MIN, cip_acu_pkg::VAL_MAX));
      add_row(16'd65535, stencil(Q1, 2 * Q1, 3 * Q1, Q1, Q1, Q1));
      add_row(16'd65535, stencil(3 * Q1, -2 * Q1, Q1, -Q1, -Q1, -Q1));
      add_row(16'd65535,
              stencil(cip_acu_pkg::VAL_MAX, 0, cip_acu_pkg::VAL_MIN,
                      cip_acu_pkg::VAL_MIN, 0, cip_acu_pkg::VAL_MAX), 1'b1,
              update(0, 0, 1'b0));
      add_row(16'd65535, stencil(Q1, cip_acu_pkg::VAL_MAX, -Q1, Q1, -Q1, Q1));

      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (dir_rows[i]) begin
         if (dir_rows[i].courant != courant_now)
            retune(dir_rows[i].courant);
         offer(dir_rows[i].item, dir_rows[i].typed, dir_rows[i].want);
         pace();
      end

      for (int p = 0; p < 6; p++) begin
         retune(phase_courant[p]);
         for (int k = 0; k < PHASE_LEN; k++) begin
            offer(random_stencil(), 1'b0, '0);
            pace();
            if (p == 2 && k == 90) begin
               idle(1);
               settle();
            end
         end
      end

      idle(1);
      settle();
      repeat (40) @(posedge clock);
      if (bad_updates == 0)
         $display("PASS");
      else
         $display("FAIL");
      $finish;
   end

endmodule

[files.f]
rtl/core/cip_acu_pkg.sv
rtl/core/cip_acu_mul.sv
rtl/core/cip_acu_front.sv
rtl/core/cip_acu_queue.sv
rtl/core/cip_acu_back.sv
rtl/core/cip_advection_cell_update_top.sv
tb/tb_cip_advection_cell_update_top.sv
